[rtl/json_string_unescape_utf8_macros.svh]
// Assertion macros shared by the unescaper RTL.
// No dependencies; included by the files that carry assertions.
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// cond must never be true outside reset
`define JSU_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// ante at an edge implies cons at the same edge
`define JSU_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/jsu_pkg.sv]
// Shared types, codes and helpers for the JSON string unescaper.
// No dependencies; used by every rtl module of the block.
package jsu_pkg;

    localparam int QDEPTH = 4;   // command queue depth between front and back

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EXPECT = 2'd1,   // expected string
        ST_BADU   = 2'd2,   // bad \u escape
        ST_MALF   = 2'd3    // malformed
    } t_status;

    typedef enum logic [6:0] {
        PH_WAIT   = 7'b0000001,
        PH_STR    = 7'b0000010,
        PH_ESC    = 7'b0000100,
        PH_HEXHI  = 7'b0001000,
        PH_NEEDBS = 7'b0010000,
        PH_NEEDU  = 7'b0100000,
        PH_HEXLO  = 7'b1000000
    } t_phase;

    typedef enum logic [1:0] {
        K_RAW   = 2'd0,   // one byte copied as is
        K_CP    = 2'd1,   // code point, sent as UTF-8
        K_EVENT = 2'd2    // status / done, no data
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [20:0] cp;      // byte in [7:0] for K_RAW
        t_status     status;
        logic        done;
    } t_cmd;

    // hex digit value, bit 4 set when not a hex digit
    function automatic logic [4:0] hexval(input logic [7:0] b);
        logic [4:0] v;
        v = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) v = 5'(b - 8'h30);
        else if (b >= 8'h61 && b <= 8'h66) v = 5'(b - 8'h57);
        else if (b >= 8'h41 && b <= 8'h46) v = 5'(b - 8'h37);
        return v;
    endfunction

endpackage

[rtl/json_string_unescape_utf8.sv]
// JSON string unescaper, text bytes in, UTF-8 string bytes out (top level).
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
//
// Input channel: i_in_valid / o_in_ready carry one text byte (i_in_byte) and
// an end-of-text flag. Output channel: o_out_valid / i_out_ready carry one
// result item: o_out_byte with o_byte_valid, o_status, o_string_done and
// o_last_of_run, which marks the final item caused by one input byte.
// Whitespace, backslashes, the opening quote and all but the last hex digit
// of a code point give no item. A plain byte gives one item, a code point 1-4.
//
// The front parser takes a byte every cycle while the command queue has room;
// each byte queues at most one command. The back end turns a command into its
// items, one per cycle while the receiver keeps up, into an output register.
// An accepted byte's command is held in the queue and then in that register.
// Sustained rate is one input byte per cycle for plain text while the receiver
// keeps up; a \u code point gives one output item per UTF-8 byte.
//
// Reset (synchronous, active low) empties the queue and output register and
// puts the parser in front of the opening quote. When the receiver stalls,
// the output item holds, the queue fills, and then o_in_ready drops.
module json_string_unescape_utf8 #(
    parameter int QDEPTH = jsu_pkg::QDEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic [1:0] o_status,
    output logic       o_string_done,
    output logic       o_last_of_run
);

    logic          accept, push, pop, q_full, q_valid;
    jsu_pkg::t_cmd f_cmd, q_cmd;

    // room for one more command is all a byte ever needs
    assign o_in_ready = !q_full;
    assign accept     = i_in_valid && o_in_ready;

    jsu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in_byte),
        .i_end    (i_end_of_text),
        .o_push   (push),
        .o_cmd    (f_cmd)
    );

    jsu_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    jsu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_cmd       (q_cmd),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_status      (o_status),
        .o_string_done (o_string_done),
        .o_last_of_run (o_last_of_run)
    );

endmodule

[rtl/jsu_front.sv]
// Front end: takes text bytes, runs the string/escape parser, issues commands.
// Depends on jsu_pkg.
module jsu_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_byte,
    input  logic           i_end,
    output logic           o_push,
    output jsu_pkg::t_cmd  o_cmd
);

    jsu_pkg::t_phase r_phase, n_phase;
    logic [1:0]      r_hex, n_hex;
    logic [15:0]     r_acc, n_acc;
    logic [9:0]      r_high, n_high;

    logic [4:0]  d;
    logic [15:0] acc_new;
    logic        ws, mvalid;
    logic [7:0]  mbyte;

    assign d       = jsu_pkg::hexval(i_byte);
    assign acc_new = {r_acc[11:0], d[3:0]};
    assign ws      = (i_byte == 8'h20) || (i_byte == 8'h09) ||
                     (i_byte == 8'h0d) || (i_byte == 8'h0a);

    // short escape table
    always_comb begin
        mvalid = 1'b1;
        mbyte  = i_byte;
        unique case (i_byte)
            8'h22, 8'h5c, 8'h2f: mbyte = i_byte;
            8'h62: mbyte = 8'h08;
            8'h66: mbyte = 8'h0c;
            8'h6e: mbyte = 8'h0a;
            8'h72: mbyte = 8'h0d;
            8'h74: mbyte = 8'h09;
            default: mvalid = 1'b0;
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_hex   = r_hex;
        n_acc   = r_acc;
        n_high  = r_high;
        o_push  = 1'b0;
        o_cmd   = '{kind: jsu_pkg::K_EVENT, cp: '0, status: jsu_pkg::ST_OK, done: 1'b0};

        unique case (r_phase)
            jsu_pkg::PH_STR: begin
                if (i_byte == 8'h22) begin
                    o_push     = 1'b1;
                    o_cmd.done = 1'b1;
                    n_phase    = jsu_pkg::PH_WAIT;
                end else if (i_byte < 8'h20 || i_end) begin
                    o_push       = 1'b1;
                    o_cmd.status = jsu_pkg::ST_MALF;
                end else if (i_byte == 8'h5c) begin
                    n_phase = jsu_pkg::PH_ESC;
                end else begin
                    o_push     = 1'b1;
                    o_cmd.kind = jsu_pkg::K_RAW;
                    o_cmd.cp   = {13'd0, i_byte};
                end
            end
            jsu_pkg::PH_ESC: begin
                if (i_byte == 8'h75) begin
                    if (i_end) begin
                        o_push       = 1'b1;
                        o_cmd.status = jsu_pkg::ST_BADU;
                    end else begin
                        n_phase = jsu_pkg::PH_HEXHI;
                        n_hex   = 2'd0;
                        n_acc   = 16'd0;
                    end
                end else if (!mvalid || i_end) begin
                    o_push       = 1'b1;
                    o_cmd.status = jsu_pkg::ST_MALF;
                end else begin
                    o_push     = 1'b1;
                    o_cmd.kind = jsu_pkg::K_RAW;
                    o_cmd.cp   = {13'd0, mbyte};
                    n_phase    = jsu_pkg::PH_STR;
                end
            end
            jsu_pkg::PH_HEXHI: begin
                if ((i_end && r_hex != 2'd3) || d[4]) begin
                    o_push       = 1'b1;
                    o_cmd.status = jsu_pkg::ST_BADU;
                end else begin
                    n_acc = acc_new;
                    if (r_hex != 2'd3) begin
                        n_hex = r_hex + 2'd1;
                    end else begin
                        n_hex = 2'd0;
                        if (acc_new >= 16'hd800 && acc_new <= 16'hdbff) begin
                            n_high  = acc_new[9:0];
                            n_phase = jsu_pkg::PH_NEEDBS;
                            if (i_end) begin
                                o_push       = 1'b1;
                                o_cmd.status = jsu_pkg::ST_MALF;
                            end
                        end else if ((acc_new >= 16'hdc00 && acc_new <= 16'hdfff) || i_end) begin
                            o_push       = 1'b1;
                            o_cmd.status = jsu_pkg::ST_MALF;
                        end else begin
                            o_push     = 1'b1;
                            o_cmd.kind = jsu_pkg::K_CP;
                            o_cmd.cp   = {5'd0, acc_new};
                            n_phase    = jsu_pkg::PH_STR;
                        end
                    end
                end
            end
            jsu_pkg::PH_NEEDBS: begin
                if (i_end || i_byte != 8'h5c) begin
                    o_push       = 1'b1;
                    o_cmd.status = jsu_pkg::ST_MALF;
                end else begin
                    n_phase = jsu_pkg::PH_NEEDU;
                end
            end
            jsu_pkg::PH_NEEDU: begin
                if (i_end || i_byte != 8'h75) begin
                    o_push       = 1'b1;
                    o_cmd.status = jsu_pkg::ST_MALF;
                end else begin
                    n_phase = jsu_pkg::PH_HEXLO;
                    n_hex   = 2'd0;
                    n_acc   = 16'd0;
                end
            end
            jsu_pkg::PH_HEXLO: begin
                if (i_end && r_hex != 2'd3) begin
                    o_push       = 1'b1;
                    o_cmd.status = jsu_pkg::ST_MALF;
                end else if (d[4]) begin
                    o_push       = 1'b1;
                    o_cmd.status = jsu_pkg::ST_BADU;
                end else begin
                    n_acc = acc_new;
                    if (r_hex != 2'd3) begin
                        n_hex = r_hex + 2'd1;
                    end else begin
                        n_hex = 2'd0;
                        if (acc_new < 16'hdc00 || acc_new > 16'hdfff || i_end) begin
                            o_push       = 1'b1;
                            o_cmd.status = jsu_pkg::ST_MALF;
                        end else begin
                            o_push     = 1'b1;
                            o_cmd.kind = jsu_pkg::K_CP;
                            o_cmd.cp   = 21'h10000 + {1'b0, r_high, acc_new[9:0]};
                            n_phase    = jsu_pkg::PH_STR;
                        end
                    end
                end
            end
            default: begin   // waiting for the opening quote
                if (ws) begin
                    if (i_end) begin
                        o_push       = 1'b1;
                        o_cmd.status = jsu_pkg::ST_EXPECT;
                    end
                end else if (i_byte == 8'h22) begin
                    n_phase = jsu_pkg::PH_STR;
                    if (i_end) begin
                        o_push       = 1'b1;
                        o_cmd.status = jsu_pkg::ST_MALF;
                    end
                end else begin
                    o_push       = 1'b1;
                    o_cmd.status = jsu_pkg::ST_EXPECT;
                end
            end
        endcase

        // any error result drops back to waiting
        if (o_push && o_cmd.kind == jsu_pkg::K_EVENT && !o_cmd.done) begin
            n_phase = jsu_pkg::PH_WAIT;
            n_hex   = 2'd0;
        end
        if (!i_accept) o_push = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= jsu_pkg::PH_WAIT;
            r_hex   <= 2'd0;
            r_acc   <= 16'd0;
            r_high  <= 10'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_hex   <= n_hex;
            r_acc   <= n_acc;
            r_high  <= n_high;
        end
    end

endmodule

[rtl/jsu_queue.sv]
// Command queue between parser front and UTF-8 back end.
// Depends on jsu_pkg and the assertion macro header.
`include "json_string_unescape_utf8_macros.svh"
module jsu_queue #(
    parameter int DEPTH = jsu_pkg::QDEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  jsu_pkg::t_cmd  i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output jsu_pkg::t_cmd  o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jsu_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            if (i_pop)  r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            if (i_push && !i_pop)      r_count <= r_count + CW'(1);
            else if (!i_push && i_pop) r_count <= r_count - CW'(1);
        end
    end

    `JSU_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full && !i_pop, "push into full queue")
    `JSU_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && !o_valid, "pop from empty queue")
    `JSU_NEVER(a_count_range, i_clk, i_rst_n, r_count > CW'(DEPTH), "queue count out of range")

endmodule

[rtl/jsu_back.sv]
// Back end: expands commands into result items, UTF-8 encoding code points.
// Depends on jsu_pkg and the assertion macro header.
`include "json_string_unescape_utf8_macros.svh"
module jsu_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  jsu_pkg::t_cmd  i_q_cmd,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [7:0]     o_out_byte,
    output logic           o_byte_valid,
    output logic [1:0]     o_status,
    output logic           o_string_done,
    output logic           o_last_of_run
);

    logic [1:0]  r_idx;
    logic        r_ov;
    logic [7:0]  r_byte;
    logic        r_bv, r_done, r_last;
    jsu_pkg::t_status r_st;

    logic [1:0]  nb_m1;     // bytes in this command minus one
    logic [7:0]  sel;
    logic        load, last;
    logic [20:0] cp;

    assign cp = i_q_cmd.cp;

    always_comb begin
        nb_m1 = 2'd0;
        if (i_q_cmd.kind == jsu_pkg::K_CP) begin
            if (cp <= 21'h7f)        nb_m1 = 2'd0;
            else if (cp <= 21'h7ff)  nb_m1 = 2'd1;
            else if (cp <= 21'hffff) nb_m1 = 2'd2;
            else                     nb_m1 = 2'd3;
        end
    end

    always_comb begin
        sel = cp[7:0];
        if (i_q_cmd.kind == jsu_pkg::K_CP) begin
            unique case (nb_m1)
                2'd1: sel = (r_idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
                2'd2: begin
                    unique case (r_idx)
                        2'd0:    sel = {4'b1110, cp[15:12]};
                        2'd1:    sel = {2'b10, cp[11:6]};
                        default: sel = {2'b10, cp[5:0]};
                    endcase
                end
                2'd3: begin
                    unique case (r_idx)
                        2'd0: sel = {5'b11110, cp[20:18]};
                        2'd1: sel = {2'b10, cp[17:12]};
                        2'd2: sel = {2'b10, cp[11:6]};
                        default: sel = {2'b10, cp[5:0]};
                    endcase
                end
                default: sel = cp[7:0];
            endcase
        end
    end

    assign load  = i_q_valid && (!r_ov || i_out_ready);
    assign last  = (r_idx == nb_m1);
    assign o_pop = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_idx <= 2'd0;
        end else begin
            if (load)             r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;
            if (load) r_idx <= last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bv   <= (i_q_cmd.kind != jsu_pkg::K_EVENT);
            r_byte <= (i_q_cmd.kind != jsu_pkg::K_EVENT) ? sel : 8'd0;
            r_st   <= i_q_cmd.status;
            r_done <= i_q_cmd.done;
            r_last <= last;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_out_byte    = r_byte;
    assign o_byte_valid  = r_bv;
    assign o_status      = r_st;
    assign o_string_done = r_done;
    assign o_last_of_run = r_last;

    `JSU_IMPLIES(a_idx_has_cmd, i_clk, i_rst_n, r_idx != 2'd0, i_q_valid && r_idx <= nb_m1, "byte index without a command")
    `JSU_IMPLIES(a_data_ok, i_clk, i_rst_n, r_ov && r_bv, r_st == jsu_pkg::ST_OK && !r_done, "data item carries status")
    `JSU_IMPLIES(a_done_clean, i_clk, i_rst_n, r_ov && r_done, !r_bv && r_last && r_st == jsu_pkg::ST_OK, "bad done item")

endmodule
